// File: rtl/arat_pkg.sv
// shared constants and controller/datapath interface types for the receiver table
// no dependencies
`default_nettype none

package arat_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = 7;
    localparam int ID_W    = 32;
    localparam int TIME_W  = 48;
    localparam int TMO_W   = 32;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 32'd120000000;

    // controller states
    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_IDLE   = 2'd0;
    localparam logic [ST_W-1:0] ST_SWEEP  = 2'd1;
    localparam logic [ST_W-1:0] ST_FINISH = 2'd2;

    typedef struct packed {
        logic start;   // capture item, clear sweep state, fetch entry 0
        logic sweep;   // evaluate current entry, fetch the next
        logic finish;  // insert if needed and load the result register
    } arat_cmd_t;

    typedef struct packed {
        logic last;    // the entry being evaluated is the final one
    } arat_status_t;

endpackage

`default_nettype wire

// File: rtl/arat_datapath.sv
// table storage, sweep compare logic, insert and result registers
// depends on arat_pkg
`default_nettype none

module arat_datapath
    import arat_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [TMO_W-1:0]  cfg_wr_data,
    input  wire logic [ID_W-1:0]   receiver_id,
    input  wire logic [TIME_W-1:0] now_us,
    input  wire arat_cmd_t         cmd,
    output arat_status_t           status,
    output logic [CNT_W-1:0]       active_count,
    output logic                   was_new,
    output logic                   table_full
);

    logic [ID_W-1:0]   id_mem   [ENTRIES];
    logic [TIME_W-1:0] seen_mem [ENTRIES];

    logic [TMO_W-1:0]   timeout_reg;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               found_reg, found_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [ID_W-1:0]    id_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [ID_W-1:0]    rd_id_reg;
    logic [TIME_W-1:0]  rd_seen_reg;
    logic [CNT_W-1:0]   count_out_reg;
    logic               new_out_reg, full_out_reg;

    logic [IDX_W-1:0]  rd_addr;
    logic [TIME_W:0]   age;
    logic              cur_valid, match, expired, keep;
    logic              do_insert;
    logic              seen_we;
    logic [IDX_W-1:0]  wr_addr;

    assign rd_addr   = cmd.start ? '0 : idx_reg + IDX_W'(1);
    assign cur_valid = valid_reg[idx_reg];
    assign match     = cur_valid && !found_reg && (rd_id_reg == id_reg);
    // borrow out of the subtract means time went backwards: never expires
    assign age       = {1'b0, now_reg} - {1'b0, rd_seen_reg};
    assign expired   = !age[TIME_W] && (age[TIME_W-1:0] >= TIME_W'(timeout_reg));
    assign keep      = cur_valid && (match || !expired);
    assign do_insert = cmd.finish && !found_reg && free_found_reg;
    assign seen_we   = (cmd.sweep && match) || do_insert;
    assign wr_addr   = cmd.finish ? free_idx_reg : idx_reg;

    assign status.last = (idx_reg == IDX_W'(ENTRIES - 1));

    always_comb
    begin
        valid_next      = valid_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        if (cmd.start)
        begin
            idx_next        = '0;
            found_next      = 1'b0;
            free_found_next = 1'b0;
            free_idx_next   = '0;
        end
        else if (cmd.sweep)
        begin
            idx_next = idx_reg + IDX_W'(1);
            if (match)
                found_next = 1'b1;
            if (cur_valid && !keep)
            begin
                valid_next[idx_reg] = 1'b0;
                count_next          = count_reg - CNT_W'(1);
            end
            if (!keep && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = idx_reg;
            end
        end
        else if (do_insert)
        begin
            valid_next[free_idx_reg] = 1'b1;
            count_next               = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= TIMEOUT_RESET;
            valid_reg      <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                timeout_reg <= cfg_wr_data;
            valid_reg      <= valid_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            id_reg  <= receiver_id;
            now_reg <= now_us;
        end
        if (cmd.finish)
        begin
            count_out_reg <= count_next;
            new_out_reg   <= do_insert;
            full_out_reg  <= !found_reg && !free_found_reg;
        end
    end

    // table memories, one write and one registered read port each
    always_ff @(posedge clk)
    begin
        if (do_insert)
            id_mem[wr_addr] <= id_reg;
        if (seen_we)
            seen_mem[wr_addr] <= now_reg;
        rd_id_reg   <= id_mem[rd_addr];
        rd_seen_reg <= seen_mem[rd_addr];
    end

    assign active_count = count_out_reg;
    assign was_new      = new_out_reg;
    assign table_full   = full_out_reg;

endmodule

`default_nettype wire

// File: rtl/arat_ctrl.sv
// controller state machine: accept, table sweep, finish, result valid
// depends on arat_pkg
`default_nettype none

module arat_ctrl
    import arat_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire arat_status_t  status,
    output arat_cmd_t          cmd
);

    logic [ST_W-1:0] state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (status.last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold until the result register can take the item
                if (slot_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: rtl/active_receiver_table_with_aging.sv
// an accepted item sweeps all 64 table entries, then the finish step loads the result register and sets result valid
// a new item is accepted only in idle, once the previous one has finished; the sweep reads one entry per cycle
// the finish step waits while a previous result is still held in the output register
// reset (rst_n, async low): all entries invalid, count zero, timeout 120000000 us
// entry id and time memories are not cleared; they are only read behind their valid bits
`default_nettype none

module active_receiver_table_with_aging
    import arat_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [TMO_W-1:0]  cfg_wr_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [ID_W-1:0]   receiver_id,
    input  wire logic [TIME_W-1:0] now_us,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [CNT_W-1:0]       active_count,
    output logic                   was_new,
    output logic                   table_full
);

    arat_cmd_t    cmd;
    arat_status_t status;

    arat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    arat_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .receiver_id  (receiver_id),
        .now_us       (now_us),
        .cmd          (cmd),
        .status       (status),
        .active_count (active_count),
        .was_new      (was_new),
        .table_full   (table_full)
    );

    // count can never pass the table size
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (active_count <= CNT_W'(ENTRIES)))
        else $error("active_count above table size");

    // an insert and a drop are exclusive
    a_new_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(was_new && table_full))
        else $error("was_new and table_full both set");

    // a fresh insert leaves at least one entry live
    a_new_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && was_new) |-> (active_count != '0))
        else $error("insert reported with empty table");

    // a dropped item means every slot is occupied
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && table_full) |-> (active_count == CNT_W'(ENTRIES)))
        else $error("drop reported with free slots");

    // an accepted item keeps the block busy through its sweep
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after accept");

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// self-checking testbench for the aging receiver table: directed and random reports
// checked against an in-bench table predictor; depends on arat_pkg and the rtl top
`default_nettype none

module testbench;
    import arat_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CNT_W-1:0] active_count;
        logic             was_new;
        logic             table_full;
    } report_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [TMO_W-1:0]  cfg_wr_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [ID_W-1:0]   receiver_id = '0;
    logic [TIME_W-1:0] now_us = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [CNT_W-1:0]  active_count;
    logic              was_new;
    logic              table_full;

    // predictor copy of the receiver table
    logic              tbl_valid [ENTRIES];
    logic [ID_W-1:0]   tbl_id    [ENTRIES];
    logic [TIME_W-1:0] tbl_seen  [ENTRIES];
    int                tbl_live;
    logic [TMO_W-1:0]  tbl_timeout;

    report_result_t    pending_results [$];
    int                fail_count;
    int                n_reports;
    int                n_inserts;
    int                n_drops;
    int                n_timeouts;
    bit                calm;

    active_receiver_table_with_aging i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .receiver_id  (receiver_id),
        .now_us       (now_us),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .active_count (active_count),
        .was_new      (was_new),
        .table_full   (table_full)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #40ms;
        $display("FAIL active_receiver_table_with_aging");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 15);
        else
            return $urandom_range(16, 80);
    endfunction

    // one sweep: refresh first match, expire stale other entries, insert into lowest free slot
    function automatic report_result_t apply_report(input logic [ID_W-1:0] id,
                                                    input logic [TIME_W-1:0] stamp);
        report_result_t res;
        logic           hit;
        int             slot;
        int             k;
        res  = '0;
        hit  = 1'b0;
        slot = -1;
        for (k = 0; k < ENTRIES; k++)
        begin
            if (tbl_valid[k])
            begin
                if (!hit && tbl_id[k] == id)
                begin
                    hit         = 1'b1;
                    tbl_seen[k] = stamp;
                end
                else if (stamp >= tbl_seen[k] &&
                         (stamp - tbl_seen[k]) >= {{(TIME_W-TMO_W){1'b0}}, tbl_timeout})
                begin
                    tbl_valid[k] = 1'b0;
                    if (tbl_live > 0)
                        tbl_live--;
                end
            end
        end
        if (!hit)
        begin
            for (k = 0; k < ENTRIES; k++)
            begin
                if (!tbl_valid[k] && slot < 0)
                    slot = k;
            end
            if (slot >= 0)
            begin
                tbl_valid[slot] = 1'b1;
                tbl_id[slot]    = id;
                tbl_seen[slot]  = stamp;
                tbl_live++;
                res.was_new     = 1'b1;
            end
            else
                res.table_full = 1'b1;
        end
        res.active_count = (tbl_live > 127) ? 7'd127 : CNT_W'(tbl_live);
        return res;
    endfunction

    // returns at the accept edge with valid still high, so the next call can chain
    task automatic send_report(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] stamp);
        int unsigned gap;
        gap = calm ? 0 : pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        receiver_id <= id;
        now_us      <= stamp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.insert(pending_results.size(), apply_report(id, stamp));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_timeout(input logic [TMO_W-1:0] tmo);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= tmo;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        tbl_timeout = tmo;
        n_timeouts++;
    endtask

    task automatic test_id_time_extremes();
        send_report('0, '0);
        send_report('1, 48'd1);
        send_report('0, '1);
        // time going backwards for the entry seen at the maximum time
        send_report(32'hA5A5_5A5A, 48'h8000_0000_0000);
    endtask

    task automatic test_zero_timeout();
        set_timeout('0);
        send_report(32'h0000_1234, 48'h8000_0000_0000);
        send_report(32'h0000_1234, 48'h8000_0000_0000);
        send_report('0, '1);
    endtask

    task automatic test_timeout_boundary();
        set_timeout(32'd1000);
        send_report(32'h55, 48'd10);
        // stale match is refreshed, not removed
        send_report(32'h55, 48'd5000);
        send_report(32'h77, 48'd6000);
        send_report(32'h78, 48'd6999);
        send_report(32'h79, 48'd7000);
    endtask

    task automatic test_max_timeout();
        set_timeout('1);
        send_report(32'h7, 48'h0);
        send_report(32'h8, 48'h0000_FFFF_FFFF);
        send_report(32'h9, 48'h0001_FFFF_FFFD);
        send_report(32'hFFFF_FFFE, 48'h7FFF_FFFF_FFFF);
    endtask

    task automatic test_table_full();
        logic [ID_W-1:0]   base;
        logic [TIME_W-1:0] t0;
        int                k;
        base = $urandom();
        t0   = {16'($urandom()), 32'($urandom())} >> 1;
        // sweep everything out at the maximum time
        set_timeout('0);
        send_report(base, '1);
        set_timeout('1);
        for (k = 1; k <= ENTRIES + 6; k++)
            send_report(base + ID_W'(k), t0 + TIME_W'(k));
        send_report(base + 32'd5, t0 + 48'd90);
        // slots freed by the same sweep take the new id
        set_timeout(32'd50);
        send_report(base + 32'd200, t0 + 48'd60);
        send_report(base + 32'd201, t0 + 48'd61);
    endtask

    task automatic test_random_aging(input logic [TMO_W-1:0] tmo, input int unsigned pool,
                                     input int unsigned step_max, input int unsigned n_items,
                                     input bit no_gaps);
        logic [ID_W-1:0]   base;
        logic [TIME_W-1:0] cur_time;
        logic [TIME_W-1:0] stamp;
        logic [ID_W-1:0]   id;
        int unsigned       r;
        int unsigned       k;
        set_timeout(tmo);
        calm     = no_gaps;
        base     = $urandom();
        cur_time = {16'($urandom()), 32'($urandom())};
        for (k = 0; k < n_items; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                id       = base + $urandom_range(0, pool - 1);
                cur_time = cur_time + TIME_W'($urandom_range(0, step_max));
                stamp    = cur_time;
            end
            else if (r < 88)
            begin
                id    = base + $urandom_range(0, pool - 1);
                stamp = cur_time - TIME_W'($urandom_range(0, step_max));
            end
            else if (r < 94)
            begin
                id       = $urandom();
                cur_time = cur_time + TIME_W'($urandom_range(0, step_max));
                stamp    = cur_time;
            end
            else
            begin
                id       = $urandom();
                cur_time = {16'($urandom()), 32'($urandom())};
                stamp    = cur_time;
            end
            send_report(id, stamp);
        end
        calm = 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            report_result_t want;
            n_reports++;
            if (was_new)
                n_inserts++;
            if (table_full)
                n_drops++;
            if (pending_results.size() == 0)
            begin
                $error("result with no report outstanding");
                fail_count++;
            end
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                if (active_count !== want.active_count)
                begin
                    $error("active_count: expected %0d, got %0d", want.active_count,
                           active_count);
                    fail_count++;
                end
                if (was_new !== want.was_new)
                begin
                    $error("was_new: expected %0d, got %0d", want.was_new, was_new);
                    fail_count++;
                end
                if (table_full !== want.table_full)
                begin
                    $error("table_full: expected %0d, got %0d", want.table_full, table_full);
                    fail_count++;
                end
            end
        end
    end

    // receiver stalls
    initial
    begin
        int unsigned gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            gap = calm ? 0 : pick_gap();
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    initial
    begin
        int k;
        for (k = 0; k < ENTRIES; k++)
            tbl_valid[k] = 1'b0;
        tbl_live    = 0;
        tbl_timeout = TIMEOUT_RESET;
        fail_count  = 0;
        n_reports   = 0;
        n_inserts   = 0;
        n_drops     = 0;
        n_timeouts  = 0;
        calm        = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_id_time_extremes();
        test_zero_timeout();
        test_timeout_boundary();
        test_max_timeout();
        test_table_full();

        test_random_aging(TIMEOUT_RESET, 24, 20000000, 300, 1'b0);
        test_random_aging(32'd1000, 100, 12, 350, 1'b0);
        test_random_aging('0, 6, 3, 150, 1'b1);
        test_random_aging(32'd1, 70, 2, 200, 1'b0);
        test_random_aging('1, 90, 32'hFFFF_FFFF, 300, 1'b0);
        test_random_aging($urandom_range(2, 5000), $urandom_range(40, 120), 200, 200, 1'b1);
        test_random_aging($urandom_range(2, 5000), $urandom_range(40, 120), 100, 200, 1'b0);

        wait_idle();
        repeat (70) @(posedge clk);
        $display("covered %0d reports over %0d timeout settings", n_reports, n_timeouts);
        $display("%0d inserts, %0d reports dropped on a full table", n_inserts, n_drops);
        if (fail_count == 0)
            $display("PASS active_receiver_table_with_aging");
        else
            $display("FAIL active_receiver_table_with_aging");
        $finish;
    end

endmodule

`default_nettype wire
